// ===== src/tbw_pkg.sv =====
package tbw_pkg;

  // Screen geometry defaults
  localparam int SCREEN_WIDTH_DEF  = 160;
  localparam int SCREEN_HEIGHT_DEF = 144;

  // Field widths
  localparam int VRAM_AW   = 13;
  localparam int VRAM_DEPTH = 1 << VRAM_AW;
  localparam int PX_W      = 8;
  localparam int GRP_W     = 5;
  localparam int CFG_IDX_W = 3;

  // Command queue between front and back
  localparam int CMD_QUEUE_DEPTH = 4;

  // Input opcodes
  localparam logic OPC_WRITE  = 1'b0;
  localparam logic OPC_RENDER = 1'b1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LCD_CONTROL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BG_PALETTE  = 3'd5;

  // Bit positions in lcd_control
  localparam int LCDC_LCD_ON   = 7;
  localparam int LCDC_WIN_MAP  = 6;
  localparam int LCDC_WIN_ON   = 5;
  localparam int LCDC_TILE_SEL = 4;
  localparam int LCDC_BG_MAP   = 3;

  // Tile maps sit at 0x1800 and 0x1C00: top two address bits set
  localparam logic [1:0]         MAP_TOP     = 2'b11;
  // Signed tile numbers: tile 0x80 lands at 0x0800
  localparam logic [VRAM_AW-1:0] SIGNED_LOW  = 13'h0800;
  localparam logic [7:0]         SIGN_FLIP   = 8'h80;
  localparam logic [PX_W:0]      WIN_OFFSET  = 9'd7;

  typedef struct packed {
    logic               opcode;
    logic [VRAM_AW-1:0] vram_address;
    logic [7:0]         vram_data;
    logic [7:0]         line;
  } in_item_t;

  typedef struct packed {
    logic [15:0]      pixels;
    logic [GRP_W-1:0] group_index;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] lcd_control;
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic [7:0] window_x;
    logic [7:0] window_y;
    logic [7:0] bg_palette;
  } cfg_t;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_RENDER = 1'b1
  } cmd_kind_t;

  // Classified command handed from front to back
  typedef struct packed {
    cmd_kind_t          kind;
    logic [VRAM_AW-1:0] addr;
    logic [7:0]         data;
    logic               win_line;
    logic [7:0]         bg_row;
    logic [7:0]         win_row;
  } cmd_t;

endpackage

// ===== src/tbw_front.sv =====
module tbw_front import tbw_pkg::*; #(
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output logic                 q_push,
  input  logic                 q_full,
  output cmd_t                 q_cmd,
  output cfg_t                 cfg
);

  cfg_t cfg_r, cfg_nxt;
  logic accept;
  logic on_screen;

  // Take register writes at any time
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_LCD_CONTROL: cfg_nxt.lcd_control = cfg_data;
        REG_SCROLL_X:    cfg_nxt.scroll_x    = cfg_data;
        REG_SCROLL_Y:    cfg_nxt.scroll_y    = cfg_data;
        REG_WINDOW_X:    cfg_nxt.window_x    = cfg_data;
        REG_WINDOW_Y:    cfg_nxt.window_y    = cfg_data;
        REG_BG_PALETTE:  cfg_nxt.bg_palette  = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

  // Hold input while the queue is full
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Classify: writes always go on, renders only for a lit, visible line
  assign on_screen = ({1'b0, in_data.line} < 9'(SCREEN_HEIGHT));
  assign q_push = accept && ((in_data.opcode == OPC_WRITE) ||
                  (cfg_r.lcd_control[LCDC_LCD_ON] && on_screen));

  // Work out per-line row values once
  always_comb begin
    q_cmd.kind     = (in_data.opcode == OPC_WRITE) ? CMD_WRITE : CMD_RENDER;
    q_cmd.addr     = in_data.vram_address;
    q_cmd.data     = in_data.vram_data;
    q_cmd.win_line = cfg_r.lcd_control[LCDC_WIN_ON] && (in_data.line >= cfg_r.window_y);
    q_cmd.bg_row   = in_data.line + cfg_r.scroll_y;
    q_cmd.win_row  = in_data.line - cfg_r.window_y;
  end

endmodule

// ===== src/tbw_fifo.sv =====
module tbw_fifo import tbw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int PTR_W = $clog2(CMD_QUEUE_DEPTH);
  localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

  cmd_t             slot_r [CMD_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  assign full      = (count_r == CNT_W'(CMD_QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_cmd   = slot_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("command pushed into a full queue");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count failed to advance on push");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CMD_QUEUE_DEPTH)) else $error("queue count beyond depth");

endmodule

// ===== src/tbw_back.sv =====
module tbw_back import tbw_pkg::*; #(
  parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_ready,
  input  cmd_t      q_cmd,
  input  cfg_t      cfg,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int GROUPS = (SCREEN_WIDTH + 7) / 8;
  localparam logic [GRP_W-1:0] LAST_GROUP = GRP_W'(GROUPS - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MAP  = 5'b00010,
    S_LO   = 5'b00100,
    S_HI   = 5'b01000,
    S_PIX  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Video memory, one write and one registered read port
  logic [7:0]         vram [VRAM_DEPTH];
  logic               mem_we;
  logic [VRAM_AW-1:0] mem_waddr;
  logic [7:0]         mem_wdata;
  logic               mem_re;
  logic [VRAM_AW-1:0] mem_raddr;
  logic [7:0]         rdata_r;

  // Line context
  logic               win_line_r, win_line_nxt;
  logic [7:0]         bg_row_r, bg_row_nxt;
  logic [7:0]         win_row_r, win_row_nxt;
  logic [PX_W-1:0]    px_r, px_nxt;
  logic [15:0]        word_r, word_nxt;

  // Fetched tile row
  logic [VRAM_AW-1:0] row_addr_r, row_addr_nxt;
  logic [7:0]         lo_r, lo_nxt;
  logic               tag_ok_r, tag_ok_nxt;
  logic               tag_win_r, tag_win_nxt;
  logic [4:0]         tag_tile_r, tag_tile_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  logic               out_free;

  // Per-pixel decode
  logic               pop;
  logic               in_screen;
  logic               win_px;
  logic [7:0]         col;
  logic [7:0]         row;
  logic               map_sel;
  logic [VRAM_AW-1:0] map_addr;
  logic [VRAM_AW-1:0] tile_base;
  logic [VRAM_AW-1:0] row_addr;
  logic [2:0]         bit_sel;
  logic [1:0]         color_id;
  logic [1:0]         shade;
  logic               need_fetch;
  logic               group_end;
  logic [15:0]        word_base;
  logic [15:0]        word_set;

  assign q_ready = (state_r == S_IDLE);
  assign pop     = q_valid && q_ready;

  // Pick the source of the current pixel
  always_comb begin
    in_screen = ({1'b0, px_r} < 9'(SCREEN_WIDTH));
    win_px    = win_line_r && (({1'b0, px_r} + WIN_OFFSET) >= {1'b0, cfg.window_x});
    col       = win_px ? (px_r + WIN_OFFSET[PX_W-1:0] - cfg.window_x)
                       : (px_r + cfg.scroll_x);
    row       = win_px ? win_row_r : bg_row_r;
    map_sel   = win_px ? cfg.lcd_control[LCDC_WIN_MAP] : cfg.lcd_control[LCDC_BG_MAP];
    map_addr  = {MAP_TOP, map_sel, row[7:3], col[7:3]};
    tile_base = cfg.lcd_control[LCDC_TILE_SEL] ? {1'b0, rdata_r, 4'b0000}
              : SIGNED_LOW + {1'b0, rdata_r ^ SIGN_FLIP, 4'b0000};
    row_addr  = tile_base | {9'b0, row[2:0], 1'b0};
    bit_sel   = ~col[2:0];
    color_id  = {rdata_r[bit_sel], lo_r[bit_sel]};
    shade     = in_screen ? cfg.bg_palette[{color_id, 1'b0} +: 2] : 2'b00;
    need_fetch = in_screen &&
                 !(tag_ok_r && (tag_win_r == win_px) && (tag_tile_r == col[7:3]));
    group_end = (px_r[2:0] == 3'b111);
    word_base = (px_r[2:0] == 3'b000) ? 16'b0 : word_r;
    word_set  = word_base | ({14'b0, shade} << {px_r[2:0], 1'b0});
  end

  assign out_free = !out_valid_r || !out_stall;

  // Sequence writes, tile fetches and pixel steps
  always_comb begin
    state_nxt     = state_r;
    win_line_nxt  = win_line_r;
    bg_row_nxt    = bg_row_r;
    win_row_nxt   = win_row_r;
    px_nxt        = px_r;
    word_nxt      = word_r;
    row_addr_nxt  = row_addr_r;
    lo_nxt        = lo_r;
    tag_ok_nxt    = tag_ok_r;
    tag_win_nxt   = tag_win_r;
    tag_tile_nxt  = tag_tile_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = q_cmd.addr;
    mem_wdata     = q_cmd.data;
    mem_re        = 1'b0;
    mem_raddr     = map_addr;

    case (state_r)
      S_IDLE: begin
        if (pop) begin
          if (q_cmd.kind == CMD_WRITE) begin
            mem_we = 1'b1;
          end else begin
            win_line_nxt = q_cmd.win_line;
            bg_row_nxt   = q_cmd.bg_row;
            win_row_nxt  = q_cmd.win_row;
            px_nxt       = '0;
            tag_ok_nxt   = 1'b0;
            state_nxt    = S_PIX;
          end
        end
      end
      S_MAP: begin
        mem_re    = 1'b1;
        mem_raddr = map_addr;
        state_nxt = S_LO;
      end
      S_LO: begin
        mem_re       = 1'b1;
        mem_raddr    = row_addr;
        row_addr_nxt = row_addr;
        state_nxt    = S_HI;
      end
      S_HI: begin
        mem_re       = 1'b1;
        mem_raddr    = row_addr_r | 13'd1;
        lo_nxt       = rdata_r;
        tag_ok_nxt   = 1'b1;
        tag_win_nxt  = win_px;
        tag_tile_nxt = col[7:3];
        state_nxt    = S_PIX;
      end
      S_PIX: begin
        if (need_fetch) begin
          state_nxt = S_MAP;
        end else if (!group_end) begin
          word_nxt = word_set;
          px_nxt   = px_r + 1'b1;
        end else if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.pixels      = word_set;
          out_data_nxt.group_index = px_r[PX_W-1:3];
          out_data_nxt.last        = (px_r[PX_W-1:3] == LAST_GROUP);
          if (px_r[PX_W-1:3] == LAST_GROUP) begin
            state_nxt = S_IDLE;
          end else begin
            px_nxt = px_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tag_ok_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tag_ok_r    <= tag_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_line_r <= win_line_nxt;
    bg_row_r   <= bg_row_nxt;
    win_row_r  <= win_row_nxt;
    px_r       <= px_nxt;
    word_r     <= word_nxt;
    row_addr_r <= row_addr_nxt;
    lo_r       <= lo_nxt;
    tag_win_r  <= tag_win_nxt;
    tag_tile_r <= tag_tile_nxt;
    out_data_r <= out_data_nxt;
  end

  // Video memory ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      vram[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= vram[mem_raddr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fetch_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAP |=> state_r == S_LO) else $error("map read not followed by tile read");

  a_last_group: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last) |-> out_data_r.group_index == LAST_GROUP)
    else $error("last flag on a group other than the final one");

  a_line_start: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_cmd.kind == CMD_RENDER) |=> (state_r == S_PIX && px_r == '0))
    else $error("render did not start at pixel zero");

  a_group_source: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |=> (!out_valid_r || $past(state_r == S_PIX)))
    else $error("result raised outside the pixel step");

endmodule

// ===== src/tile_background_window_line_render_top.sv =====
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_stall   in_item_t (opcode, vram_address, vram_data, line)
// out_     output     out_valid / out_stall out_item_t (pixels, group_index, last)
// cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data (six 8-bit registers)
//
// A video memory write is made as the command leaves the queue. A rendered line steps
// through its pixels in turn and, for each tile crossed, reads the map entry, then the
// low and high tile bytes through the single memory read port; a stalled result holds
// the pixel step. Reset (rst_n low, synchronous) clears registers, queue and sequencer;
// video memory holds nothing defined until written. A four-entry command queue lets input
// transfers continue while a line is still being rendered.
module tile_background_window_line_render_top import tbw_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic q_push;
  logic q_full;
  cmd_t q_in_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_out_cmd;
  cfg_t cfg;

  // Accept and classify input transfers
  tbw_front #(
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_cmd    (q_in_cmd),
    .cfg      (cfg)
  );

  // Decouple front and back
  tbw_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .full     (q_full),
    .push_cmd (q_in_cmd),
    .pop_valid(q_valid),
    .pop_ready(q_ready),
    .pop_cmd  (q_out_cmd)
  );

  // Carry out writes and line renders
  tbw_back #(
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_out_cmd),
    .cfg      (cfg),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import tbw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIXELS        = SCREEN_WIDTH_DEF;
  localparam int LINES         = SCREEN_HEIGHT_DEF;
  localparam int GROUPS        = (PIXELS + 7) / 8;
  localparam int SETTLE_CYCLES = 1200;
  localparam int HOLD_CYCLES   = 600;
  localparam int RANDOM_PHASES = 13;
  localparam int PHASE_ITEMS   = 20;
  localparam time RUN_LIMIT    = 20_000_000;

  // lcd_control bit positions
  localparam int LCD_ON_BIT   = 7;
  localparam int WIN_MAP_BIT  = 6;
  localparam int WIN_ON_BIT   = 5;
  localparam int TILE_SEL_BIT = 4;
  localparam int BG_MAP_BIT   = 3;

  // Video memory layout
  localparam logic [VRAM_AW-1:0] MAP_LO_BASE      = 13'h1800;
  localparam logic [VRAM_AW-1:0] MAP_HI_BASE      = 13'h1C00;
  localparam logic [VRAM_AW-1:0] SIGNED_TILE_BASE = 13'h0800;
  localparam logic [7:0]         TILE_SIGN_MASK   = 8'h80;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = '0;

  // Shadow copy of the block state
  logic [7:0] vram_model [VRAM_DEPTH];
  cfg_t       lcd_regs = '0;
  out_item_t  expected_groups [$];

  // Idle control for both sides
  bit in_idle_en  = 1'b1;
  bit out_idle_en = 1'b1;
  int rx_hold_req = 0;
  int rx_hold_left = 0;

  int errors         = 0;
  int groups_checked = 0;
  int renders_sent   = 0;
  int writes_sent    = 0;
  int cfg_phases     = 0;
  out_item_t want;

  tile_background_window_line_render_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Shade of one pixel at map column col, map row row
  function automatic logic [1:0] tile_shade(logic [VRAM_AW-1:0] map_base, logic [7:0] col,
                                            logic [7:0] row);
    logic [7:0]         entry;
    logic [7:0]         lo_byte;
    logic [7:0]         hi_byte;
    logic [VRAM_AW-1:0] tile_base;
    logic [VRAM_AW-1:0] row_addr;
    logic [1:0]         color_id;
    int                 b;
    entry = vram_model[map_base + {3'b000, row[7:3], col[7:3]}];
    if (lcd_regs.lcd_control[TILE_SEL_BIT]) begin
      tile_base = {1'b0, entry, 4'h0};
    end else begin
      tile_base = SIGNED_TILE_BASE + {1'b0, entry ^ TILE_SIGN_MASK, 4'h0};
    end
    row_addr = tile_base + {9'b0, row[2:0], 1'b0};
    lo_byte  = vram_model[row_addr];
    hi_byte  = vram_model[row_addr + 13'd1];
    b        = 7 - col[2:0];
    color_id = {hi_byte[b], lo_byte[b]};
    return lcd_regs.bg_palette[2*color_id +: 2];
  endfunction

  // Queue the pixel groups one line render gives
  task automatic expect_line_groups(logic [7:0] line);
    logic               win_line;
    logic [VRAM_AW-1:0] bg_map;
    logic [VRAM_AW-1:0] win_map;
    logic [7:0]         bg_row;
    logic [7:0]         win_row;
    logic [7:0]         col;
    out_item_t          grp;
    int                 i;
    if (!lcd_regs.lcd_control[LCD_ON_BIT] || line >= LINES) return;
    win_line = lcd_regs.lcd_control[WIN_ON_BIT] && (line >= lcd_regs.window_y);
    bg_map   = lcd_regs.lcd_control[BG_MAP_BIT] ? MAP_HI_BASE : MAP_LO_BASE;
    win_map  = lcd_regs.lcd_control[WIN_MAP_BIT] ? MAP_HI_BASE : MAP_LO_BASE;
    bg_row   = line + lcd_regs.scroll_y;
    win_row  = line - lcd_regs.window_y;
    for (int g = 0; g < GROUPS; g++) begin
      grp.pixels = '0;
      for (int k = 0; k < 8; k++) begin
        i = g * 8 + k;
        if (i < PIXELS) begin
          if (win_line && (i + 7 >= lcd_regs.window_x)) begin
            col = i + 7 - lcd_regs.window_x;
            grp.pixels[2*k +: 2] = tile_shade(win_map, col, win_row);
          end else begin
            col = i + lcd_regs.scroll_x;
            grp.pixels[2*k +: 2] = tile_shade(bg_map, col, bg_row);
          end
        end
      end
      grp.group_index = g;
      grp.last        = (g == GROUPS - 1);
      expected_groups.push_back(grp);
    end
  endtask

  // Offer one item, hold it until the transfer, then update the shadow state
  task automatic send_item(in_item_t it);
    while (in_idle_en && ($urandom_range(99) < 20)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.opcode == OPC_WRITE) begin
      vram_model[it.vram_address] = it.vram_data;
      writes_sent++;
    end else begin
      expect_line_groups(it.line);
      renders_sent++;
    end
  endtask

  // Drop valid and wait for every queued group to arrive
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_groups.size() != 0) @(posedge clk);
  endtask

  // Write all six registers back to back
  task automatic write_config(cfg_t c);
    logic [CFG_IDX_W-1:0] reg_idx [6];
    logic [7:0]           reg_val [6];
    reg_idx = '{REG_LCD_CONTROL, REG_SCROLL_X, REG_SCROLL_Y,
                REG_WINDOW_X, REG_WINDOW_Y, REG_BG_PALETTE};
    reg_val = '{c.lcd_control, c.scroll_x, c.scroll_y, c.window_x, c.window_y, c.bg_palette};
    for (int r = 0; r < 6; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx[r];
      cfg_data  <= reg_val[r];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    lcd_regs = c;
  endtask

  // Reconfigure only once the block has gone quiet
  task automatic apply_config(cfg_t c);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_config(c);
    cfg_phases++;
  endtask

  function automatic cfg_t make_cfg(logic [7:0] lcdc, logic [7:0] sx, logic [7:0] sy,
                                    logic [7:0] wx, logic [7:0] wy, logic [7:0] pal);
    cfg_t c;
    c.lcd_control = lcdc;
    c.scroll_x    = sx;
    c.scroll_y    = sy;
    c.window_x    = wx;
    c.window_y    = wy;
    c.bg_palette  = pal;
    return c;
  endfunction

  function automatic in_item_t render_of(logic [7:0] line);
    in_item_t it;
    it.opcode       = OPC_RENDER;
    it.vram_address = $urandom;
    it.vram_data    = $urandom;
    it.line         = line;
    return it;
  endfunction

  function automatic in_item_t write_of(logic [VRAM_AW-1:0] addr, logic [7:0] data);
    in_item_t it;
    it.opcode       = OPC_WRITE;
    it.vram_address = addr;
    it.vram_data    = data;
    it.line         = $urandom;
    return it;
  endfunction

  // Bias towards the byte extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.lcd_control = pick_byte();
    if ($urandom_range(99) < 85) c.lcd_control[LCD_ON_BIT] = 1'b1;
    c.scroll_x = pick_byte();
    c.scroll_y = pick_byte();
    case ($urandom_range(3))
      0:       c.window_x = $urandom_range(14);
      1:       c.window_x = $urandom_range(170, 150);
      default: c.window_x = pick_byte();
    endcase
    c.window_y   = ($urandom_range(3) == 0) ? pick_byte() : $urandom_range(LINES);
    c.bg_palette = $urandom;
    return c;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    logic [7:0] line;
    case ($urandom_range(9))
      7: begin
        case ($urandom_range(3))
          0:       line = 8'd0;
          1:       line = LINES - 1;
          2:       line = LINES;
          default: line = 8'hFF;
        endcase
      end
      8, 9:    line = $urandom;
      default: line = $urandom_range(LINES - 1);
    endcase
    if ($urandom_range(99) < 45) it = render_of(line);
    else it = write_of($urandom, $urandom);
    return it;
  endfunction

  // Receiver: random stall, or a long counted hold when asked
  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left--;
    end else begin
      out_stall <= out_idle_en && ($urandom_range(99) < 20);
    end
  end

  // Compare each result transfer with the oldest queued group
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_groups.size() == 0) begin
        $display("%0t: unexpected result pixels=%h group=%0d last=%0d", $time,
                 out_data.pixels, out_data.group_index, out_data.last);
        errors++;
      end else begin
        want = expected_groups.pop_front();
        if (out_data.pixels !== want.pixels) begin
          $display("%0t: pixels mismatch, expected %h actual %h (group %0d)", $time,
                   want.pixels, out_data.pixels, want.group_index);
          errors++;
        end
        if (out_data.group_index !== want.group_index) begin
          $display("%0t: group_index mismatch, expected %0d actual %0d", $time,
                   want.group_index, out_data.group_index);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last mismatch, expected %0d actual %0d (group %0d)", $time,
                   want.last, out_data.last, want.group_index);
          errors++;
        end
        groups_checked++;
      end
    end
  end

  // Fill the whole memory so no render reads an unwritten byte
  task automatic test_preload();
    for (int a = 0; a < VRAM_DEPTH; a++) begin
      if (a == 0) send_item(write_of(a, 8'h00));
      else if (a == VRAM_DEPTH - 1) send_item(write_of(a, 8'hFF));
      else send_item(write_of(a, $urandom));
    end
  endtask

  task automatic test_directed();
    // LCD off: renders give nothing
    apply_config(make_cfg(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(render_of(8'd0));
    send_item(render_of(8'd100));
    // Signed tiles, low map; set tile row bytes to show colour bit order
    apply_config(make_cfg(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE4));
    send_item(write_of(MAP_LO_BASE, 8'h80));
    send_item(write_of(SIGNED_TILE_BASE, 8'h0F));
    send_item(write_of(SIGNED_TILE_BASE + 13'd1, 8'hF0));
    send_item(render_of(8'd0));
    send_item(render_of(LINES - 1));
    send_item(render_of(LINES));
    send_item(render_of(8'hFF));
    // Everything on, window from pixel 0, maximum scroll
    apply_config(make_cfg(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h1B));
    send_item(render_of(8'd0));
    send_item(render_of(LINES - 1));
    // Window starts on the last line only
    apply_config(make_cfg(8'hB7, 8'd13, 8'd200, 8'd7, LINES - 1, 8'h9C));
    send_item(render_of(LINES - 2));
    send_item(render_of(LINES - 1));
    // Window covers only the rightmost pixel
    apply_config(make_cfg(8'hE8, 8'd100, 8'd50, PIXELS + 6, 8'd10, 8'hFF));
    send_item(render_of(8'd10));
    send_item(render_of(8'd50));
    // Window on but placed past the screen
    apply_config(make_cfg(8'hA0, 8'd3, 8'd0, 8'hFF, 8'd0, 8'h6C));
    send_item(render_of(8'd20));
    // All other control bits set with the LCD off
    apply_config(make_cfg(8'h7F, 8'd0, 8'd0, 8'd0, 8'd0, 8'hE4));
    send_item(render_of(8'd5));
  endtask

  task automatic test_random();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_config(random_config());
      repeat (PHASE_ITEMS) send_item(random_item());
    end
  endtask

  // Hold the receiver off while renders keep coming, then pause until empty
  task automatic test_back_pressure();
    apply_config(make_cfg(8'hF8, 8'd37, 8'd91, 8'd60, 8'd30, 8'hD2));
    rx_hold_req = HOLD_CYCLES;
    for (int n = 0; n < 10; n++) send_item(render_of(n * 13));
    drain_results();
    repeat (5) send_item(random_item());
  endtask

  task automatic test_no_idle();
    apply_config(random_config());
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    repeat (25) send_item(random_item());
    drain_results();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);
    test_preload();
    test_directed();
    test_random();
    test_back_pressure();
    test_no_idle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d memory writes and %0d line renders over %0d register settings,",
             writes_sent, renders_sent, cfg_phases);
    $display("with %0d pixel groups checked and %0d mismatches.", groups_checked, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT);
    $display("simulation failed");
    $finish;
  end

endmodule
